FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion checked on every rising edge, disabled while reset is low.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Assertion checked on every rising edge, reset included.
`define ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/vcis_pkg.sv
// ----------------------------------------------------------------------------
// vcis_pkg
// Types, constants and helpers of the VLAN class inter-arrival statistics core.
// ----------------------------------------------------------------------------
package vcis_pkg;

  localparam int unsigned NUM_CLASSES_DEF = 8;

  localparam logic [15:0] TPID_VLAN     = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd18;
  localparam logic [11:0] VID_RESET     = 12'd100;
  localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

  // drop reason codes
  localparam logic [2:0] DROP_NONE     = 3'd0;
  localparam logic [2:0] DROP_SHORT    = 3'd1;
  localparam logic [2:0] DROP_UNTAGGED = 3'd2;
  localparam logic [2:0] DROP_VID      = 3'd3;
  localparam logic [2:0] DROP_NOT_IPV4 = 3'd4;

  typedef struct packed {
    logic [15:0] capture_length;
    logic [63:0] timestamp_us;
    logic [15:0] tag_protocol;
    logic [15:0] tag_control;
    logic [15:0] inner_protocol;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  drop_reason;
    logic [2:0]  traffic_class;
    logic [11:0] vlan_id;
    logic [31:0] class_count;
    logic [63:0] interval_us;
    logic [63:0] min_gap_us;
    logic [63:0] max_gap_us;
    logic [63:0] interval_sum_us;
    logic [63:0] first_seen_us;
    logic [31:0] total_accepted;
  } out_item_t;

  // one class record as held in the table
  typedef struct packed {
    logic [31:0] count;
    logic [63:0] first_time;
    logic [63:0] last_time;
    logic [63:0] interval_sum;
    logic [63:0] min_interval;
    logic [63:0] max_interval;
  } class_rec_t;

  localparam class_rec_t REC_RESET = '{
    count:        '0,
    first_time:   '0,
    last_time:    '0,
    interval_sum: '0,
    min_interval: '1,
    max_interval: '0
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_OUTPUT
  } state_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

FILE: hdl/vcis_ram.sv
// ----------------------------------------------------------------------------
// vcis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vcis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/vlan_class_interarrival_stats_core.sv
// ----------------------------------------------------------------------------
// vlan_class_interarrival_stats_core
// Per-traffic-class inter-arrival statistics for 802.1Q tagged IPv4 frames.
// ----------------------------------------------------------------------------
// Each input transfer carries one frame's header words and its capture time
// in microseconds. Frames shorter than 18 bytes, untagged frames, frames whose
// VID differs from cfg_wr_data's last value (0 = match any, reset value 100)
// and non-IPv4 frames are dropped and reported with their drop reason; the
// class table is left alone. Accepted frames use the PCP as the class and
// update that class's record: count (saturating), first/last timestamp, sum
// of intervals (mod 2^64), min and max interval. Every input transfer yields
// exactly one output transfer. No new frame is taken until the last result
// has gone to the output register, which waits on a stalled output side.
// Steps per frame: accept and launch the table read, capture the record and
// form the interval, update and write the record back, hand the result to
// the output register. The class table lives in a RAM with registered read
// data; per-class valid flops make never-written classes read as their reset
// record, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module vlan_class_interarrival_stats_core
  import vcis_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input frames
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // target VID register
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data
);

  `include "assert_macros.svh"

  localparam int unsigned CLS_W   = $clog2(NUM_CLASSES);
  localparam int unsigned REC_W   = $bits(class_rec_t);

  state_t state_r, state_nxt;

  logic [11:0]      target_vid_r;
  logic [NUM_CLASSES-1:0] vld_r;
  logic [31:0]      total_r;

  // captured frame
  logic [63:0]      ts_r;
  logic [11:0]      vid_r;
  logic [CLS_W-1:0] cls_r;
  logic [2:0]       reason_r, reason_nxt;

  // read stage
  class_rec_t       rec_r;
  logic             first_r;
  logic [63:0]      interval_r;

  // result waiting for the output register
  out_item_t        res_r, res_nxt;
  out_item_t        out_data_r;
  logic             out_valid_r;

  // table port
  logic             ram_re, ram_we;
  logic [CLS_W-1:0] in_cls;
  logic [REC_W-1:0] ram_rdata;
  class_rec_t       rd_rec, upd_rec;

  logic             accept;
  logic             out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_cls   = in_data.tag_control[13 +: CLS_W];

  // --------------------------------------------------------------------------
  // Frame filter, evaluated on the incoming transfer
  // --------------------------------------------------------------------------
  always_comb begin
    if (in_data.capture_length < MIN_FRAME_LEN) begin
      reason_nxt = DROP_SHORT;
    end else if (in_data.tag_protocol != TPID_VLAN) begin
      reason_nxt = DROP_UNTAGGED;
    end else if (target_vid_r != 12'd0 && in_data.tag_control[11:0] != target_vid_r) begin
      reason_nxt = DROP_VID;
    end else if (in_data.inner_protocol != ETYPE_IPV4) begin
      reason_nxt = DROP_NOT_IPV4;
    end else begin
      reason_nxt = DROP_NONE;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_READ;
      S_READ:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_OUTPUT;
      S_OUTPUT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ram_re   = in_valid;
      end
      S_UPDATE: ram_we = (reason_r == DROP_NONE);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Class table
  // --------------------------------------------------------------------------
  vcis_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_CLASSES)
  ) u_class_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cls_r),
    .wdata (upd_rec),
    .re    (ram_re),
    .raddr (in_cls),
    .rdata (ram_rdata)
  );

  // a class never written reads as its reset record
  assign rd_rec = vld_r[cls_r] ? class_rec_t'(ram_rdata) : REC_RESET;

  // record update; the first packet of a class sets the first time and no interval statistics
  always_comb begin
    upd_rec           = rec_r;
    upd_rec.count     = sat_inc32(rec_r.count);
    upd_rec.last_time = ts_r;
    if (first_r) begin
      upd_rec.first_time = ts_r;
    end else begin
      upd_rec.interval_sum = rec_r.interval_sum + interval_r;
      if (interval_r < rec_r.min_interval) upd_rec.min_interval = interval_r;
      if (interval_r > rec_r.max_interval) upd_rec.max_interval = interval_r;
    end
  end

  // result of the frame in flight
  always_comb begin
    res_nxt                = '0;
    res_nxt.drop_reason    = reason_r;
    res_nxt.total_accepted = total_r;
    if (reason_r == DROP_NONE) begin
      res_nxt.traffic_class   = 3'(cls_r);
      res_nxt.vlan_id         = vid_r;
      res_nxt.class_count     = upd_rec.count;
      res_nxt.interval_us     = interval_r;
      // no interval yet while the class holds a single packet
      res_nxt.min_gap_us      = (upd_rec.count >= 32'd2) ? upd_rec.min_interval
                                                         : 64'd0;
      res_nxt.max_gap_us      = upd_rec.max_interval;
      res_nxt.interval_sum_us = upd_rec.interval_sum;
      res_nxt.first_seen_us   = upd_rec.first_time;
      res_nxt.total_accepted  = sat_inc32(total_r);
    end else if (reason_r == DROP_VID || reason_r == DROP_NOT_IPV4) begin
      res_nxt.vlan_id = vid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_vid_r <= VID_RESET;
      vld_r        <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_vid_r <= cfg_wr_data;
      end
      if (ram_we) begin
        vld_r[cls_r] <= 1'b1;
        total_r      <= sat_inc32(total_r);
      end
      if (state_r == S_OUTPUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      ts_r     <= in_data.timestamp_us;
      vid_r    <= in_data.tag_control[11:0];
      cls_r    <= in_cls;
      reason_r <= reason_nxt;
    end
    if (state_r == S_READ) begin
      rec_r      <= rd_rec;
      first_r    <= !vld_r[cls_r];
      interval_r <= vld_r[cls_r] ? (ts_r - rd_rec.last_time) : 64'd0;
    end
    if (state_r == S_UPDATE) begin
      res_r <= res_nxt;
    end
    if (state_r == S_OUTPUT && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_RST(a_wb_only_accepted, clk, rst_n, ram_we |-> (reason_r == DROP_NONE), "write-back of a dropped frame")
  `ASSERT_RST(a_out_from_seq, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_OUTPUT), "result without sequencer")
  `ASSERT_RST(a_drop_no_stats, clk, rst_n, (out_valid && out_data.drop_reason != DROP_NONE) |-> (out_data.class_count == 32'd0), "dropped frame with class stats")
  `ASSERT_RST(a_no_accept_busy, clk, rst_n, (state_r != S_IDLE) |-> !ram_re, "table read while busy")

endmodule

FILE: bench/vcis_stats_checker.sv
// ----------------------------------------------------------------------------
// vcis_stats_checker
// Scoreboard for the VLAN class inter-arrival statistics core.
// ----------------------------------------------------------------------------
// Watches the frame, result and register ports. It keeps its own copy of the
// VID filter and the per-class table, works out the result of each frame
// transfer, and compares each result transfer field by field with the oldest
// prediction. The failure count and the number of results still owed are
// handed to the top.
// ----------------------------------------------------------------------------
module vcis_stats_checker
  import vcis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          frames_passed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCLS = NUM_CLASSES_DEF;

  logic [11:0] vid_filter;
  logic [31:0] pkt_count  [NCLS];
  logic [63:0] first_ts   [NCLS];
  logic [63:0] last_ts    [NCLS];
  logic [63:0] gap_sum    [NCLS];
  logic [63:0] gap_min    [NCLS];
  logic [63:0] gap_max    [NCLS];
  logic [31:0] passed_total;

  out_item_t expected_stats [$];
  out_item_t oldest;
  int        errs      = 0;
  int        n_checked = 0;
  int        n_passed  = 0;

  // filter the frame, then update the class record it selects
  function automatic out_item_t predict_class_stats(input in_item_t f);
    out_item_t   r;
    logic [2:0]  cls;
    logic [11:0] vid;
    logic [63:0] gap;
    r   = '0;
    cls = f.tag_control[15:13];
    vid = f.tag_control[11:0];
    gap = '0;
    if (f.capture_length < MIN_FRAME_LEN) r.drop_reason = DROP_SHORT;
    else if (f.tag_protocol != TPID_VLAN) r.drop_reason = DROP_UNTAGGED;
    else if (vid_filter != '0 && vid != vid_filter) r.drop_reason = DROP_VID;
    else if (f.inner_protocol != ETYPE_IPV4) r.drop_reason = DROP_NOT_IPV4;
    else r.drop_reason = DROP_NONE;

    if (r.drop_reason != DROP_NONE) begin
      if (r.drop_reason == DROP_VID || r.drop_reason == DROP_NOT_IPV4) r.vlan_id = vid;
      r.total_accepted = passed_total;
      return r;
    end

    if (pkt_count[cls] == '0) begin
      first_ts[cls] = f.timestamp_us;
      gap_min[cls]  = '1;
    end else begin
      gap          = f.timestamp_us - last_ts[cls];
      gap_sum[cls] = gap_sum[cls] + gap;
      if (gap < gap_min[cls]) gap_min[cls] = gap;
      if (gap > gap_max[cls]) gap_max[cls] = gap;
    end
    last_ts[cls] = f.timestamp_us;
    if (pkt_count[cls] != '1) pkt_count[cls] = pkt_count[cls] + 32'd1;
    if (passed_total != '1) passed_total = passed_total + 32'd1;

    r.traffic_class   = cls;
    r.vlan_id         = vid;
    r.class_count     = pkt_count[cls];
    r.interval_us     = gap;
    r.min_gap_us      = (pkt_count[cls] >= 32'd2) ? gap_min[cls] : '0;
    r.max_gap_us      = gap_max[cls];
    r.interval_sum_us = gap_sum[cls];
    r.first_seen_us   = first_ts[cls];
    r.total_accepted  = passed_total;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp,
                             input logic [63:0] act);
    if (act !== exp) begin
      errs++;
      if (errs <= 10)
        $display("%t: result %0d field %s: expected %h, got %h",
                 $realtime, n_checked, name, exp, act);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      vid_filter   = VID_RESET;
      passed_total = '0;
      for (int k = 0; k < NCLS; k++) begin
        pkt_count[k] = '0;
        first_ts[k]  = '0;
        last_ts[k]   = '0;
        gap_sum[k]   = '0;
        gap_min[k]   = '1;
        gap_max[k]   = '0;
      end
      expected_stats.delete();
    end else begin
      if (cfg_wr_en) vid_filter = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_stats.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%t: result transfer with no frame outstanding", $realtime);
        end else begin
          oldest = expected_stats.pop_front();
          check_field("drop_reason",     64'(oldest.drop_reason),   64'(out_data.drop_reason));
          check_field("traffic_class",   64'(oldest.traffic_class), 64'(out_data.traffic_class));
          check_field("vlan_id",         64'(oldest.vlan_id),       64'(out_data.vlan_id));
          check_field("class_count",     64'(oldest.class_count),   64'(out_data.class_count));
          check_field("interval_us",     oldest.interval_us,        out_data.interval_us);
          check_field("min_gap_us",      oldest.min_gap_us,         out_data.min_gap_us);
          check_field("max_gap_us",      oldest.max_gap_us,         out_data.max_gap_us);
          check_field("interval_sum_us", oldest.interval_sum_us,    out_data.interval_sum_us);
          check_field("first_seen_us",   oldest.first_seen_us,      out_data.first_seen_us);
          check_field("total_accepted",  64'(oldest.total_accepted), 64'(out_data.total_accepted));
          n_checked++;
        end
      end
      if (in_valid && in_ready) begin
        expected_stats.push_back(predict_class_stats(in_data));
        if (expected_stats[$].drop_reason == DROP_NONE) n_passed++;
      end
    end
    fail_count      <= errs;
    pending         <= expected_stats.size();
    results_checked <= n_checked;
    frames_passed   <= n_passed;
  end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the VLAN class inter-arrival statistics core.
// ----------------------------------------------------------------------------
// Drives a directed set of frames (every drop reason, first packet of a
// class, backward timestamps, field extremes, VID filter off and at its
// limits), then random frames in eight phases, each with its own VID
// setting and one of four flow-control modes. The checker beside the
// block predicts and compares; this module only makes traffic and reports the outcome.
// ----------------------------------------------------------------------------
module testbench
  import vcis_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // ~1700 frames; the limit is many times the slowest run
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 8;
  localparam int FRAMES_PER_PH = 212;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  in_item_t    in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [11:0] cfg_wr_data = '0;

  int fail_count;
  int pending;
  int results_checked;
  int frames_passed;

  int          send_idle  = 0;    // percent of cycles the sender holds off
  int          recv_stall = 0;    // percent of cycles the receiver stalls
  int          cycles     = 0;
  int          frames_sent = 0;
  int          vid_settings = 0;
  logic [63:0] ts_clock   = 64'd10000;
  logic [11:0] cur_target = VID_RESET;

  vlan_class_interarrival_stats_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  vcis_stats_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .frames_passed   (frames_passed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends up here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: backpressure decided fresh each cycle, at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic in_item_t make_frame(input logic [15:0] len, input logic [63:0] ts,
                                          input logic [15:0] tpid, input logic [15:0] tci,
                                          input logic [15:0] inner);
    in_item_t f;
    f.capture_length = len;
    f.timestamp_us   = ts;
    f.tag_protocol   = tpid;
    f.tag_control    = tci;
    f.inner_protocol = inner;
    return f;
  endfunction

  // mostly small forward steps; sometimes a huge jump (wraps, hits high bits),
  // sometimes a stamp behind the running clock
  function automatic logic [63:0] next_timestamp();
    int roll;
    roll = $urandom_range(99);
    if (roll < 88) begin
      ts_clock = ts_clock + 64'($urandom_range(2000));
      return ts_clock;
    end
    if (roll < 94) begin
      ts_clock = ts_clock + {$urandom, $urandom};
      return ts_clock;
    end
    return ts_clock - 64'($urandom_range(5000, 1));
  endfunction

  // well-formed tagged IPv4 frame for the current filter, or one broken field
  function automatic in_item_t random_frame();
    in_item_t    f;
    int          roll;
    logic [11:0] vid;
    roll = $urandom_range(99);
    vid  = (cur_target == '0) ? 12'($urandom) : cur_target;
    f.capture_length = ($urandom_range(3) == 0) ? MIN_FRAME_LEN
                                                : 16'($urandom_range(65535, 18));
    f.timestamp_us   = next_timestamp();
    f.tag_protocol   = TPID_VLAN;
    f.tag_control    = {3'($urandom), 1'($urandom), vid};
    f.inner_protocol = ETYPE_IPV4;
    if (roll >= 96)      f.capture_length       = 16'($urandom_range(17));
    else if (roll >= 92) f.tag_protocol         = 16'($urandom);
    else if (roll >= 88) f.tag_control[11:0]    = 12'($urandom);
    else if (roll >= 84) f.inner_protocol       = 16'($urandom);
    return f;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  // Valid is left high so a back-to-back frame needs no second assignment.
  task automatic send_frame(input in_item_t f);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    frames_sent++;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold off the sender until every frame so far has its result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_target(input logic [11:0] vid);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= vid;
    cur_target  = vid;
    vid_settings++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [11:0] ph_target [PHASES];

    ph_target[0] = 12'd0;
    ph_target[1] = VID_RESET;
    ph_target[2] = 12'hFFF;
    ph_target[3] = 12'($urandom);
    ph_target[4] = 12'd1;
    ph_target[5] = 12'($urandom);
    ph_target[6] = 12'd0;
    ph_target[7] = 12'($urandom);

    // reset held from the start, released at a falling edge
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, filter at its reset value of 100
    send_frame(make_frame(16'd0,  64'd1, TPID_VLAN, 16'h0064, ETYPE_IPV4));   // too short
    send_frame(make_frame(16'd17, 64'd2, TPID_VLAN, 16'h0064, ETYPE_IPV4));   // one byte short
    send_frame(make_frame(16'd18, 64'd3, 16'h0000,  16'h0064, ETYPE_IPV4));   // untagged
    send_frame(make_frame(16'd18, 64'd4, TPID_VLAN, 16'h8065, ETYPE_IPV4));   // VID 101
    send_frame(make_frame(16'd64, 64'd5, TPID_VLAN, 16'h0064, 16'h86DD));     // not IPv4
    // class 0: first packet, forward step, then a stamp going backwards
    send_frame(make_frame(16'd64, 64'd1000, TPID_VLAN, 16'h0064, ETYPE_IPV4));
    send_frame(make_frame(16'd64, 64'd1500, TPID_VLAN, 16'h0064, ETYPE_IPV4));
    send_frame(make_frame(16'd64, 64'd1200, TPID_VLAN, 16'h0064, ETYPE_IPV4));
    // class 7 near the top of the time range, DEI set, max length; then wrap
    send_frame(make_frame(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF0, TPID_VLAN, 16'hF064, ETYPE_IPV4));
    send_frame(make_frame(16'd18, 64'd5, TPID_VLAN, 16'hF064, ETYPE_IPV4));
    send_frame(make_frame(16'd18, 64'd9, TPID_VLAN, 16'hE064, ETYPE_IPV4));
    for (int k = 1; k < 7; k++)
      send_frame(make_frame(16'd100, 64'(2000 + k), TPID_VLAN,
                            {3'(k), 1'b0, 12'd100}, ETYPE_IPV4));
    // all-ones header that still fails on length
    send_frame(make_frame(16'd17, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    // filter off: VID 0 and 4095 both pass
    drain();
    write_target(12'd0);
    send_frame(make_frame(16'd40, 64'd3000, TPID_VLAN, 16'h6000, ETYPE_IPV4));
    send_frame(make_frame(16'd40, 64'd3100, TPID_VLAN, 16'h6FFF, ETYPE_IPV4));
    // filter at its top value
    drain();
    write_target(12'hFFF);
    send_frame(make_frame(16'd40, 64'd3200, TPID_VLAN, 16'h6FFF, ETYPE_IPV4));
    send_frame(make_frame(16'd40, 64'd3300, TPID_VLAN, 16'h6000, ETYPE_IPV4));
    send_frame(make_frame(16'd40, 64'd3400, TPID_VLAN, 16'h6064, ETYPE_IPV4));

    // random phases: new VID setting each, flow-control mode cycles
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_target(ph_target[p]);
      case (p % 4)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 48;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 48;
        end
        default: begin
          send_idle  = 11;
          recv_stall = 11;
        end
      endcase
      for (int i = 0; i < FRAMES_PER_PH; i++) begin
        // mid-phase hold-off until the pipeline is empty
        if (p == 1 && i == FRAMES_PER_PH / 2) drain();
        send_frame(random_frame());
      end
    end

    drain();
    repeat (16) @(posedge clk);

    $display("Sent %0d frames (%0d passed the filter), %0d results compared.",
             frames_sent, frames_passed, results_checked);
    $display("Covered all drop reasons, %0d VID settings and four flow-control modes.",
             vid_settings);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
